### rtl/mdat_pkg.sv
// Shared types and constants for the multichannel deadline alarm table.
// No dependencies; every RTL file of the block imports this package.
`default_nettype none

package mdat_pkg;

    localparam int DEADLINE_W = 32;
    localparam logic [DEADLINE_W-1:0] NO_DEADLINE = {DEADLINE_W{1'b1}};
    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [7:0] MAX_MINUTES_RESET = 8'd60;

    typedef enum logic [1:0] {
        KIND_ARMED     = 2'd0,
        KIND_REJECTED  = 2'd1,
        KIND_ALARM     = 2'd2,
        KIND_BATCH_END = 2'd3
    } event_kind_t;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ARM  = 1'b1;

    // Per-cycle control of one table cell.
    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/mdat_cell.sv
// One deadline cell of the table ring.
// Depends on mdat_pkg for the deadline width, reset value and control struct.
`default_nettype none

module mdat_cell
    import mdat_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cell_ctrl_t            ctrl,
    input  wire logic [DEADLINE_W-1:0] shift_in,
    input  wire logic [DEADLINE_W-1:0] wr_data,
    output logic      [DEADLINE_W-1:0] value
);

    logic [DEADLINE_W-1:0] value_reg;
    logic [DEADLINE_W-1:0] value_next;

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.shift)
        begin
            value_next = shift_in;
        end
        else if (ctrl.write)
        begin
            value_next = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= NO_DEADLINE;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

### rtl/multichannel_deadline_alarm_table.sv
// Top level of the multichannel deadline alarm table: cell ring and scan control.
// Depends on mdat_pkg and mdat_cell.
//
// An arm request or a tick gives at most one beat. A tick whose time passes
// the earliest deadline starts a scan: the deadlines rotate through the ring
// of CHANNELS cells one position a cycle while the output is not stalled, past
// the compare logic at the head, and the scan is followed by a batch-end beat
// when any channel expired. A stall on the output holds the scan in place.
// No input beat is taken during a scan.
`default_nettype none

module multichannel_deadline_alarm_table
    import mdat_pkg::*;
#(
    parameter int CHANNELS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_write,
    input  wire logic [7:0]            cfg_data,

    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  opcode,
    input  wire logic [7:0]            channel_index,
    input  wire logic [7:0]            duration_minutes,
    input  wire logic [DEADLINE_W-1:0] now_seconds,

    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [1:0]                 event_kind,
    output logic [3:0]                 event_channel,
    output logic [DEADLINE_W-1:0]      deadline_seconds,
    output logic                       last_of_run
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int EXT_W = (IDX_W > 4) ? IDX_W : 4;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    state_t                state_reg, state_next;
    logic [7:0]            max_minutes_reg, max_minutes_next;
    logic [DEADLINE_W-1:0] current_reg, current_next;
    logic [DEADLINE_W-1:0] earliest_reg, earliest_next;
    logic [IDX_W-1:0]      scan_idx_reg, scan_idx_next;
    logic                  hit_reg, hit_next;

    logic                  out_valid_reg, out_valid_next;
    event_kind_t           kind_reg, kind_next;
    logic [3:0]            channel_reg, channel_next;
    logic [DEADLINE_W-1:0] deadline_reg, deadline_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic                  in_accept;
    logic                  arm_ok;
    logic [DEADLINE_W-1:0] arm_deadline;
    logic [13:0]           arm_seconds;
    logic                  head_expired;
    logic [DEADLINE_W-1:0] writeback;
    logic                  shift_en;
    logic [EXT_W-1:0]      scan_idx_ext;

    logic [DEADLINE_W-1:0] cell_value [CHANNELS];

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;

    assign arm_ok = ({1'b0, channel_index} < 9'(CHANNELS))
                    && (duration_minutes <= max_minutes_reg)
                    && (current_reg != '0);
    assign arm_seconds  = 14'(duration_minutes) * 14'(SECONDS_PER_MINUTE);
    assign arm_deadline = DEADLINE_W'(arm_seconds) + current_reg;

    // The head cell holds the channel under test; an expired channel goes back
    // into the ring cleared.
    assign head_expired = cell_value[0] < current_reg;
    assign writeback    = head_expired ? NO_DEADLINE : cell_value[0];
    assign shift_en     = (state_reg == ST_SCAN) && out_free;
    assign scan_idx_ext = EXT_W'(scan_idx_reg);

    genvar k;
    generate
        for (k = 0; k < CHANNELS; k++)
        begin : g_cell
            cell_ctrl_t            ctrl;
            logic [DEADLINE_W-1:0] shift_in;

            assign ctrl.shift = shift_en;
            assign ctrl.write = in_accept && (opcode == OP_ARM) && arm_ok
                                && (channel_index == 8'(k));
            if (k == CHANNELS - 1)
            begin : g_tail
                assign shift_in = writeback;
            end
            else
            begin : g_body
                assign shift_in = cell_value[k+1];
            end

            mdat_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .shift_in (shift_in),
                .wr_data  (arm_deadline),
                .value    (cell_value[k])
            );
        end
    endgenerate

    always_comb
    begin
        state_next       = state_reg;
        max_minutes_next = max_minutes_reg;
        current_next     = current_reg;
        earliest_next    = earliest_reg;
        scan_idx_next    = scan_idx_reg;
        hit_next         = hit_reg;
        out_valid_next   = out_valid_reg && out_stall;
        kind_next        = kind_reg;
        channel_next     = channel_reg;
        deadline_next    = deadline_reg;
        last_next        = last_reg;

        if (cfg_write)
        begin
            max_minutes_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (opcode == OP_ARM)
                    begin
                        out_valid_next = 1'b1;
                        last_next      = 1'b1;
                        if (arm_ok)
                        begin
                            kind_next     = KIND_ARMED;
                            channel_next  = channel_index[3:0];
                            deadline_next = arm_deadline;
                            if (arm_deadline < earliest_reg)
                            begin
                                earliest_next = arm_deadline;
                            end
                        end
                        else
                        begin
                            kind_next     = KIND_REJECTED;
                            channel_next  = '0;
                            deadline_next = '0;
                        end
                    end
                    else
                    begin
                        current_next = now_seconds;
                        if (earliest_reg < now_seconds)
                        begin
                            state_next    = ST_SCAN;
                            earliest_next = NO_DEADLINE;
                            scan_idx_next = '0;
                            hit_next      = 1'b0;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (head_expired)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_ALARM;
                        channel_next   = scan_idx_ext[3:0];
                        deadline_next  = cell_value[0];
                        last_next      = 1'b0;
                        hit_next       = 1'b1;
                    end
                    else if (cell_value[0] < earliest_reg)
                    begin
                        earliest_next = cell_value[0];
                    end
                    if (scan_idx_reg == IDX_W'(CHANNELS - 1))
                    begin
                        state_next = (hit_reg || head_expired) ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_BATCH_END;
                    channel_next   = '0;
                    deadline_next  = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            max_minutes_reg <= MAX_MINUTES_RESET;
            current_reg     <= '0;
            earliest_reg    <= NO_DEADLINE;
            scan_idx_reg    <= '0;
            hit_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            max_minutes_reg <= max_minutes_next;
            current_reg     <= current_next;
            earliest_reg    <= earliest_next;
            scan_idx_reg    <= scan_idx_next;
            hit_reg         <= hit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        channel_reg  <= channel_next;
        deadline_reg <= deadline_next;
        last_reg     <= last_next;
    end

    assign out_valid        = out_valid_reg;
    assign event_kind       = kind_reg;
    assign event_channel    = channel_reg;
    assign deadline_seconds = deadline_reg;
    assign last_of_run      = last_reg;

    // A tick past the earliest deadline must start a scan.
    a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && opcode == OP_TICK && earliest_reg < now_seconds)
            |=> (state_reg == ST_SCAN))
        else $error("expired tick did not start a scan");

    // The batch-end beat is only owed when an alarm went out.
    a_flush_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> hit_reg)
        else $error("batch end pending without any alarm");

    // Alarm beats never close a run; the batch-end beat always does.
    a_alarm_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_ALARM) |-> !last_reg)
        else $error("alarm beat marked as last of run");

    // The scan only advances while the output register can take a beat.
    a_scan_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && out_valid_reg && out_stall)
            |=> $stable(scan_idx_reg))
        else $error("scan advanced under output stall");

endmodule

`default_nettype wire
